### rtl/core/qru_pkg.sv
// ----------------------------------------------------------------------------
// qru_pkg
// shared types, operation codes and fixed-point helpers of the quaternion unit
// ----------------------------------------------------------------------------
package qru_pkg;

    localparam int COMP_WIDTH  = 16;
    localparam int FRAC_BITS   = 14;
    localparam int INNER_WIDTH = 32;
    localparam int ACC_WIDTH   = 48;
    localparam int ELEMS       = 9;

    typedef logic signed [COMP_WIDTH-1:0]  t_comp;
    typedef logic signed [INNER_WIDTH-1:0] t_inner;
    typedef logic signed [ACC_WIDTH-1:0]   t_acc;

    localparam logic [1:0] OP_PRODUCT = 2'd0;
    localparam logic [1:0] OP_ROTATE  = 2'd1;
    localparam logic [1:0] OP_MATRIX  = 2'd2;
    localparam logic [1:0] OP_NONE    = 2'd3;  // unknown code, no result

    typedef struct packed {
        logic [1:0] operation;
        t_comp      q_w;
        t_comp      q_x;
        t_comp      q_y;
        t_comp      q_z;
        t_comp      r_w;
        t_comp      r_x;
        t_comp      r_y;
        t_comp      r_z;
    } t_in;

    typedef struct packed {
        t_comp      out_w;
        t_comp      out_x;
        t_comp      out_y;
        t_comp      out_z;
        logic [1:0] row_index;
        logic       last;
        logic       overflow;
    } t_out;

    // stage bundle between datapath and emitter
    typedef struct packed {
        logic       valid;
        logic [1:0] op;
        logic       ovf;
    } t_ctl;

    function automatic t_acc mul(input t_comp a, input t_inner b);
        return t_acc'(a) * t_acc'(b);
    endfunction

    // round to nearest, ties up
    function automatic t_acc rnd(input t_acc p, input int s);
        return (p + (t_acc'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic logic ovf_w(input t_acc v, input int w);
        t_acc hi;
        t_acc lo;
        hi = (t_acc'(1) <<< (w - 1)) - t_acc'(1);
        lo = -(t_acc'(1) <<< (w - 1));
        return (v > hi) || (v < lo);
    endfunction

    function automatic t_acc sat_w(input t_acc v, input int w);
        t_acc hi;
        t_acc lo;
        hi = (t_acc'(1) <<< (w - 1)) - t_acc'(1);
        lo = -(t_acc'(1) <<< (w - 1));
        if (v > hi) begin
            return hi;
        end else if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

endpackage

### rtl/core/qru_datapath.sv
// ----------------------------------------------------------------------------
// qru_datapath
// four-stage arithmetic pipe: products, sums, second cross product, rotate sum
// ----------------------------------------------------------------------------
module qru_datapath import qru_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_in  i_cmd,
    output t_ctl o_ctl,
    output t_acc o_elem [ELEMS]
);

    localparam int F = FRAC_BITS;
    localparam int D = FRAC_BITS - 1;

    // stage 1: rounded products
    logic  r1_valid, n1_valid;
    t_in   r1_cmd;
    t_acc  r1_p [16];
    t_acc  n1_p [16];
    t_comp a [16];
    t_comp b [16];

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            a[i] = '0;
            b[i] = '0;
        end
        unique case (i_cmd.operation)
            OP_PRODUCT: begin
                a[0]  = i_cmd.q_w; b[0]  = i_cmd.r_w;
                a[1]  = i_cmd.q_x; b[1]  = i_cmd.r_x;
                a[2]  = i_cmd.q_y; b[2]  = i_cmd.r_y;
                a[3]  = i_cmd.q_z; b[3]  = i_cmd.r_z;
                a[4]  = i_cmd.q_w; b[4]  = i_cmd.r_x;
                a[5]  = i_cmd.q_x; b[5]  = i_cmd.r_w;
                a[6]  = i_cmd.q_y; b[6]  = i_cmd.r_z;
                a[7]  = i_cmd.q_z; b[7]  = i_cmd.r_y;
                a[8]  = i_cmd.q_w; b[8]  = i_cmd.r_y;
                a[9]  = i_cmd.q_y; b[9]  = i_cmd.r_w;
                a[10] = i_cmd.q_z; b[10] = i_cmd.r_x;
                a[11] = i_cmd.q_x; b[11] = i_cmd.r_z;
                a[12] = i_cmd.q_w; b[12] = i_cmd.r_z;
                a[13] = i_cmd.q_z; b[13] = i_cmd.r_w;
                a[14] = i_cmd.q_x; b[14] = i_cmd.r_y;
                a[15] = i_cmd.q_y; b[15] = i_cmd.r_x;
            end
            OP_ROTATE: begin
                a[0] = i_cmd.q_y; b[0] = i_cmd.r_z;
                a[1] = i_cmd.q_z; b[1] = i_cmd.r_y;
                a[2] = i_cmd.q_z; b[2] = i_cmd.r_x;
                a[3] = i_cmd.q_x; b[3] = i_cmd.r_z;
                a[4] = i_cmd.q_x; b[4] = i_cmd.r_y;
                a[5] = i_cmd.q_y; b[5] = i_cmd.r_x;
            end
            OP_MATRIX: begin
                a[0] = i_cmd.q_x; b[0] = i_cmd.q_x;
                a[1] = i_cmd.q_y; b[1] = i_cmd.q_y;
                a[2] = i_cmd.q_z; b[2] = i_cmd.q_z;
                a[3] = i_cmd.q_x; b[3] = i_cmd.q_y;
                a[4] = i_cmd.q_x; b[4] = i_cmd.q_z;
                a[5] = i_cmd.q_y; b[5] = i_cmd.q_z;
                a[6] = i_cmd.q_w; b[6] = i_cmd.q_x;
                a[7] = i_cmd.q_w; b[7] = i_cmd.q_y;
                a[8] = i_cmd.q_w; b[8] = i_cmd.q_z;
            end
            default: begin
            end
        endcase
        for (int i = 0; i < 16; i++) begin
            if (i_cmd.operation == OP_MATRIX) begin
                n1_p[i] = rnd(mul(a[i], t_inner'(b[i])), D);
            end else begin
                n1_p[i] = rnd(mul(a[i], t_inner'(b[i])), F);
            end
        end
        // unknown operation yields nothing
        n1_valid = i_valid && (i_cmd.operation != OP_NONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= n1_valid;
        end
        r1_cmd <= i_cmd;
        r1_p   <= n1_p;
    end

    // stage 2: sums, first cross product, matrix elements
    logic r2_valid;
    t_in  r2_cmd;
    logic r2_ovf, n2_ovf;
    t_acc r2_e [ELEMS];
    t_acc n2_e [ELEMS];
    t_acc one;
    t_acc d2 [3];

    always_comb begin
        one    = t_acc'(1) <<< FRAC_BITS;
        n2_ovf = 1'b0;
        for (int i = 0; i < ELEMS; i++) begin
            n2_e[i] = '0;
        end
        for (int i = 0; i < 3; i++) begin
            d2[i] = r1_p[2*i] - r1_p[2*i+1];
        end
        unique case (r1_cmd.operation)
            OP_PRODUCT: begin
                n2_e[0] = r1_p[0] - r1_p[1] - r1_p[2] - r1_p[3];
                n2_e[1] = r1_p[4] + r1_p[5] + r1_p[6] - r1_p[7];
                n2_e[2] = r1_p[8] + r1_p[9] + r1_p[10] - r1_p[11];
                n2_e[3] = r1_p[12] + r1_p[13] + r1_p[14] - r1_p[15];
            end
            OP_ROTATE: begin
                for (int i = 0; i < 3; i++) begin
                    n2_e[i] = sat_w(d2[i], INNER_WIDTH);
                    n2_ovf  = n2_ovf | ovf_w(d2[i], INNER_WIDTH);
                end
            end
            OP_MATRIX: begin
                n2_e[0] = one - (r1_p[1] + r1_p[2]);
                n2_e[1] = r1_p[3] - r1_p[8];
                n2_e[2] = r1_p[4] + r1_p[7];
                n2_e[3] = r1_p[3] + r1_p[8];
                n2_e[4] = one - (r1_p[0] + r1_p[2]);
                n2_e[5] = r1_p[5] - r1_p[6];
                n2_e[6] = r1_p[4] - r1_p[7];
                n2_e[7] = r1_p[5] + r1_p[6];
                n2_e[8] = one - (r1_p[0] + r1_p[1]);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
        r2_cmd <= r1_cmd;
        r2_ovf <= n2_ovf;
        r2_e   <= n2_e;
    end

    // stage 3: u x (u x v) and w (u x v) products
    logic   r3_valid;
    t_in    r3_cmd;
    logic   r3_ovf;
    t_acc   r3_e [ELEMS];
    t_acc   n3_e [ELEMS];
    t_inner uv [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            uv[i] = t_inner'(r2_e[i]);
        end
        if (r2_cmd.operation == OP_ROTATE) begin
            n3_e[0] = rnd(mul(r2_cmd.q_y, uv[2]), F);
            n3_e[1] = rnd(mul(r2_cmd.q_z, uv[1]), F);
            n3_e[2] = rnd(mul(r2_cmd.q_z, uv[0]), F);
            n3_e[3] = rnd(mul(r2_cmd.q_x, uv[2]), F);
            n3_e[4] = rnd(mul(r2_cmd.q_x, uv[1]), F);
            n3_e[5] = rnd(mul(r2_cmd.q_y, uv[0]), F);
            for (int i = 0; i < 3; i++) begin
                n3_e[6+i] = rnd(mul(r2_cmd.q_w, uv[i]), D);
            end
        end else begin
            n3_e = r2_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r2_valid;
        end
        r3_cmd <= r2_cmd;
        r3_ovf <= r2_ovf;
        r3_e   <= n3_e;
    end

    // stage 4: rotated vector sum
    logic r4_valid;
    logic [1:0] r4_op;
    logic r4_ovf, n4_ovf;
    t_acc r4_e [ELEMS];
    t_acc n4_e [ELEMS];
    t_acc d4 [3];
    t_acc uuv [3];
    t_acc vv [3];

    always_comb begin
        n4_ovf = r3_ovf;
        n4_e   = r3_e;
        vv[0]  = t_acc'(r3_cmd.r_x);
        vv[1]  = t_acc'(r3_cmd.r_y);
        vv[2]  = t_acc'(r3_cmd.r_z);
        for (int i = 0; i < 3; i++) begin
            d4[i]  = r3_e[2*i] - r3_e[2*i+1];
            uuv[i] = sat_w(d4[i], INNER_WIDTH);
        end
        if (r3_cmd.operation == OP_ROTATE) begin
            n4_e[0] = '0;
            for (int i = 0; i < 3; i++) begin
                n4_ovf    = n4_ovf | ovf_w(d4[i], INNER_WIDTH);
                n4_e[1+i] = vv[i] + r3_e[6+i] + (uuv[i] <<< 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else begin
            r4_valid <= r3_valid;
        end
        r4_op  <= r3_cmd.operation;
        r4_ovf <= n4_ovf;
        r4_e   <= n4_e;
    end

    assign o_ctl  = '{valid: r4_valid, op: r4_op, ovf: r4_ovf};
    assign o_elem = r4_e;

endmodule

### rtl/core/qru_emit.sv
// ----------------------------------------------------------------------------
// qru_emit
// output saturation and matrix row sequencing into the result register
// ----------------------------------------------------------------------------
module qru_emit import qru_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_ctl i_ctl,
    input  t_acc i_elem [ELEMS],
    output logic o_valid,
    output t_out o_result
);

    logic       r_valid, n_valid;
    t_out       r_out, n_out;
    logic [1:0] r_row, n_row;
    logic       r_ovf, n_ovf;
    t_acc       r_rows [6];
    t_acc       sel [4];
    logic       sel_ovf;
    logic [1:0] sel_row;
    logic       sel_last;

    always_comb begin
        n_row    = r_row;
        n_ovf    = r_ovf;
        n_valid  = 1'b0;
        sel      = '{default: '0};
        sel_ovf  = 1'b0;
        sel_row  = 2'd0;
        sel_last = 1'b1;
        if (i_ctl.valid) begin
            n_valid = 1'b1;
            sel_ovf = i_ctl.ovf;
            if (i_ctl.op == OP_MATRIX) begin
                sel[1]   = i_elem[0];
                sel[2]   = i_elem[1];
                sel[3]   = i_elem[2];
                sel_last = 1'b0;
                n_row    = 2'd1;
                n_ovf    = i_ctl.ovf;
            end else begin
                for (int j = 0; j < 4; j++) begin
                    sel[j] = i_elem[j];
                end
            end
        end else if (r_row != 2'd0) begin
            // remaining matrix rows
            n_valid = 1'b1;
            sel_ovf = r_ovf;
            sel_row = r_row;
            if (r_row == 2'd1) begin
                sel[1]   = r_rows[0];
                sel[2]   = r_rows[1];
                sel[3]   = r_rows[2];
                sel_last = 1'b0;
                n_row    = 2'd2;
            end else begin
                sel[1] = r_rows[3];
                sel[2] = r_rows[4];
                sel[3] = r_rows[5];
                n_row  = 2'd0;
            end
        end
        n_out.out_w     = t_comp'(sat_w(sel[0], COMP_WIDTH));
        n_out.out_x     = t_comp'(sat_w(sel[1], COMP_WIDTH));
        n_out.out_y     = t_comp'(sat_w(sel[2], COMP_WIDTH));
        n_out.out_z     = t_comp'(sat_w(sel[3], COMP_WIDTH));
        n_out.row_index = sel_row;
        n_out.last      = sel_last;
        n_out.overflow  = sel_ovf | ovf_w(sel[0], COMP_WIDTH) | ovf_w(sel[1], COMP_WIDTH)
                        | ovf_w(sel[2], COMP_WIDTH) | ovf_w(sel[3], COMP_WIDTH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_row   <= 2'd0;
        end else begin
            r_valid <= n_valid;
            r_row   <= n_row;
        end
        r_out <= n_out;
        r_ovf <= n_ovf;
        if (i_ctl.valid && (i_ctl.op == OP_MATRIX)) begin
            for (int j = 0; j < 6; j++) begin
                r_rows[j] <= i_elem[3+j];
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_out;

endmodule

### rtl/core/quaternion_rotation_unit.sv
// ----------------------------------------------------------------------------
// quaternion_rotation_unit
// fixed-point quaternion product, vector rotation and rotation matrix rows
// ----------------------------------------------------------------------------
//  channel   ports                  direction  beat taken when
//  command   start, busy, i_cmd     in         start && !busy
//  result    o_valid, o_result      out        o_valid (one cycle each)
//
//  a command beat passes the datapath stage registers and the result register
//  before its first result beat; product and rotate give one beat each, matrix
//  gives rows 0 to 2 and raises busy after its beat to reserve slots for rows 1, 2
//  synchronous active-low reset clears all valid bits and the row counter
//  the receiver cannot stall, so the pipe never holds
// ----------------------------------------------------------------------------
module quaternion_rotation_unit import qru_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_cmd,
    output logic o_valid,
    output t_out o_result
);

    logic       accept;
    logic [1:0] r_hold, n_hold;
    t_ctl       ctl;
    t_acc       elem [ELEMS];

    assign accept = start && !busy;
    assign busy   = (r_hold != 2'd0);

    // matrix beats reserve two extra output slots
    always_comb begin
        n_hold = r_hold;
        if (accept && (i_cmd.operation == OP_MATRIX)) begin
            n_hold = 2'd2;
        end else if (r_hold != 2'd0) begin
            n_hold = r_hold - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= 2'd0;
        end else begin
            r_hold <= n_hold;
        end
    end

    qru_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_cmd   (i_cmd),
        .o_ctl   (ctl),
        .o_elem  (elem)
    );

    qru_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_elem   (elem),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    // a matrix beat raises busy to block further commands
    a_matrix_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_cmd.operation == OP_MATRIX)) |=> busy)
        else $error("matrix beat not followed by busy");

    // a non-final row is always followed by another row
    a_rows_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.last) |=> o_valid)
        else $error("matrix row sequence broken");

    // a row with index 2 is always marked last
    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result.row_index == 2'd2)) |-> o_result.last)
        else $error("row 2 not marked last");

    // pipeline slot never collides with pending rows
    a_no_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.valid |-> !(o_valid && !o_result.last)))
        else $error("pipeline result collides with matrix rows");

endmodule
